>>> rtl/hvd_pkg.sv
// Shared types, constants and tables for the haversine distance pipeline.
package hvd_pkg;

  // Fraction bits of the degree inputs
  localparam int ANGLE_FRAC_BITS = 20;

  localparam int CORDIC_STEPS = 30;
  localparam int ROOT_STEPS   = 31;
  localparam int STEP_W       = 5;

  // CORDIC datapath width (signed Q30 with headroom)
  localparam int DW = 34;
  // Square-root datapath width
  localparam int RW = 62;
  // Highest bit weight of the root search (2^60)
  localparam int ROOT_TOP = 60;

  // Input, conversion, rotation rows, product stages, roots, vector row, output
  localparam int LATENCY = 3 + CORDIC_STEPS + 8 + ROOT_STEPS + CORDIC_STEPS + 2;

  typedef logic signed [DW-1:0] cdc_t;

  typedef struct packed {
    cdc_t x;
    cdc_t y;
    cdc_t z;
  } cdc_vec_t;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [RW-1:0] res;
  } root_t;

  localparam logic [31:0] LAT_LIMIT = 32'(90) << ANGLE_FRAC_BITS;
  localparam logic [31:0] LON_LIMIT = 32'(180) << ANGLE_FRAC_BITS;

  localparam logic [34:0] DEG_TO_RAD = 35'd19190098069;
  localparam logic [17:0] DEG_LO = DEG_TO_RAD[17:0];
  localparam logic [16:0] DEG_HI = DEG_TO_RAD[34:18];

  localparam int SH_FULL = ANGLE_FRAC_BITS + 10;
  localparam int SH_HALF = ANGLE_FRAC_BITS + 11;
  localparam logic [65:0] RND_FULL = 66'(1) << (SH_FULL - 1);
  localparam logic [65:0] RND_HALF = 66'(1) << (SH_HALF - 1);

  localparam logic [35:0] HALF_PI_Q30 = 36'd1686629713;
  localparam logic [35:0] PI_Q30      = 36'd3373259426;
  localparam cdc_t GAIN_INV_Q30 = 34'sd652032874;
  localparam logic [22:0] EARTH_RADIUS = 23'd6371000;
  localparam logic [29:0] DIST_MAX = 30'd320241392;
  localparam logic [60:0] ONE_Q60 = 61'(1) << 60;

  localparam logic [31:0] ARC_TABLE [CORDIC_STEPS] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
    32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
    32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
    32'd128, 32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2
  };

  // Arctangent of 2^-step in Q30
  function automatic cdc_t arc_angle(input logic [STEP_W-1:0] step);
    return $signed({2'b00, ARC_TABLE[step]});
  endfunction

endpackage

>>> rtl/hvd_cordic_cell.sv
// One CORDIC micro-rotation step, rotation or vectoring mode, registered.
module hvd_cordic_cell (
  input  logic                         clk,
  input  logic                         en,
  input  logic [hvd_pkg::STEP_W-1:0]   step,
  input  logic                         vector,
  input  hvd_pkg::cdc_vec_t            d_in,
  output hvd_pkg::cdc_vec_t            d_out
);

  hvd_pkg::cdc_t xi, yi, zi, dx, dy, arc;
  logic up;
  hvd_pkg::cdc_vec_t d_next;

  // Pick direction and apply the shifted cross terms
  always_comb begin
    xi  = $signed(d_in.x);
    yi  = $signed(d_in.y);
    zi  = $signed(d_in.z);
    dx  = yi >>> step;
    dy  = xi >>> step;
    arc = hvd_pkg::arc_angle(step);
    up  = vector ? (yi <= 0) : (zi >= 0);
    if (up) begin
      d_next.x = xi - dx;
      d_next.y = yi + dy;
      d_next.z = zi - arc;
    end else begin
      d_next.x = xi + dx;
      d_next.y = yi - dy;
      d_next.z = zi + arc;
    end
  end

  // Advance to the next cell
  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= d_next;
    end
  end

endmodule

>>> rtl/hvd_cordic_row.sv
// Row of CORDIC cells, one step per cell, one item per cycle while en is high.
module hvd_cordic_row (
  input  logic              clk,
  input  logic              en,
  input  logic              vector,
  input  hvd_pkg::cdc_vec_t d_in,
  output hvd_pkg::cdc_vec_t d_out
);

  hvd_pkg::cdc_vec_t link [hvd_pkg::CORDIC_STEPS+1];

  assign link[0] = d_in;
  assign d_out   = link[hvd_pkg::CORDIC_STEPS];

  // Chain the cells
  for (genvar i = 0; i < hvd_pkg::CORDIC_STEPS; i++) begin : g_cell
    hvd_cordic_cell u_cell (
      .clk    (clk),
      .en     (en),
      .step   (hvd_pkg::STEP_W'(i)),
      .vector (vector),
      .d_in   (link[i]),
      .d_out  (link[i+1])
    );
  end

endmodule

>>> rtl/hvd_root_cell.sv
// One digit-pair step of an integer square root, registered.
module hvd_root_cell (
  input  logic                       clk,
  input  logic                       en,
  input  logic [hvd_pkg::STEP_W-1:0] step,
  input  hvd_pkg::root_t             d_in,
  output hvd_pkg::root_t             d_out
);

  logic [5:0] shamt;
  logic [hvd_pkg::RW-1:0] bitv, trial;
  hvd_pkg::root_t d_next;

  // Trial subtract at this bit weight
  always_comb begin
    shamt = 6'(hvd_pkg::ROOT_TOP) - {step, 1'b0};
    bitv  = hvd_pkg::RW'(1) << shamt;
    trial = d_in.res + bitv;
    if (d_in.rem >= trial) begin
      d_next.rem = d_in.rem - trial;
      d_next.res = (d_in.res >> 1) + bitv;
    end else begin
      d_next.rem = d_in.rem;
      d_next.res = d_in.res >> 1;
    end
  end

  // Advance to the next cell
  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= d_next;
    end
  end

endmodule

>>> rtl/haversine_distance.sv
// Top level: pipelined haversine great-circle distance.
//
//   channel | signals                                   | direction
//   item    | item_valid, item_ready, four coordinates  | in
//   result  | result_valid, result_ready,               | out
//           | distance_sixteenths, coords_valid         |
//
// One pair enters per cycle unless the output stalls; the pair passes through
// 104 register stages up to result_valid: two CORDIC rows of 30 cells in series
// (the four rotation rows run side by side), two root rows of 31 cells side by
// side and 13 conversion, product and output stages.
// Reset clears only the stage valid bits.
// A result held at the output stalls the whole pipeline; input ready follows.
module haversine_distance (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  logic signed [28:0] first_latitude,
  input  logic signed [28:0] first_longitude,
  input  logic signed [28:0] second_latitude,
  input  logic signed [28:0] second_longitude,
  output logic               result_valid,
  input  logic               result_ready,
  output logic [28:0]        distance_sixteenths,
  output logic               coords_valid
);

  localparam int LAT = hvd_pkg::LATENCY;

  function automatic logic [29:0] mag30(input logic [29:0] v);
    return v[29] ? (~v + 30'd1) : v;
  endfunction

  function automatic logic [30:0] clamp_q30(input hvd_pkg::cdc_t v);
    logic [30:0] r;
    if (v < 0) r = '0;
    else if (v > 34'sd1073741824) r = 31'd1073741824;
    else r = 31'(v);
    return r;
  endfunction

  logic en;
  logic vld [LAT];
  logic okp [LAT-1];

  assign en           = !vld[LAT-1] || result_ready;
  assign item_ready   = en;
  assign result_valid = vld[LAT-1];

  // Track the stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= item_valid;
      for (int i = 1; i < LAT; i++) vld[i] <= vld[i-1];
    end
  end

  // Stage 1: magnitudes and range check
  logic [29:0] lat1, lat2, lon1, lon2;
  logic [29:0] m_next [4];
  logic [29:0] mlon1, mlon2;
  logic ok_next;
  logic [29:0] m1 [4];

  always_comb begin
    lat1 = {first_latitude[28], first_latitude};
    lat2 = {second_latitude[28], second_latitude};
    lon1 = {first_longitude[28], first_longitude};
    lon2 = {second_longitude[28], second_longitude};
    m_next[0] = mag30(lat1 - lat2);
    m_next[1] = mag30(lon1 - lon2);
    m_next[2] = mag30(lat1);
    m_next[3] = mag30(lat2);
    mlon1 = mag30(lon1);
    mlon2 = mag30(lon2);
    ok_next = ({2'b00, m_next[2]} <= hvd_pkg::LAT_LIMIT) &&
              ({2'b00, m_next[3]} <= hvd_pkg::LAT_LIMIT) &&
              ({2'b00, mlon1} <= hvd_pkg::LON_LIMIT) &&
              ({2'b00, mlon2} <= hvd_pkg::LON_LIMIT);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1 <= m_next;
      okp[0] <= ok_next;
      for (int i = 1; i < LAT-1; i++) okp[i] <= okp[i-1];
    end
  end

  // Stage 2: split products for degree to radian conversion
  logic [47:0] p_lo [4];
  logic [46:0] p_hi [4];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        p_lo[k] <= 48'(m1[k]) * 48'(hvd_pkg::DEG_LO);
        p_hi[k] <= 47'(m1[k]) * 47'(hvd_pkg::DEG_HI);
      end
    end
  end

  // Stage 3: round, scale, clamp or fold into the first quadrant
  logic [65:0] full [4];
  logic [35:0] rad [4];
  logic [31:0] ang_next [4];
  logic [31:0] ang [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      full[k] = 66'({p_hi[k], 18'b0}) + 66'(p_lo[k]) +
                ((k < 2) ? hvd_pkg::RND_HALF : hvd_pkg::RND_FULL);
      rad[k]  = (k < 2) ? 36'(full[k] >> hvd_pkg::SH_HALF)
                        : 36'(full[k] >> hvd_pkg::SH_FULL);
      if (rad[k] <= hvd_pkg::HALF_PI_Q30) begin
        ang_next[k] = 32'(rad[k]);
      end else if (k != 1) begin
        ang_next[k] = 32'(hvd_pkg::HALF_PI_Q30);
      end else if (rad[k] > hvd_pkg::PI_Q30) begin
        ang_next[k] = '0;
      end else begin
        ang_next[k] = 32'(hvd_pkg::PI_Q30 - rad[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang <= ang_next;
    end
  end

  // Rotation rows: half differences and both latitudes
  hvd_pkg::cdc_vec_t rot_in [4];
  hvd_pkg::cdc_vec_t rot_out [4];

  for (genvar k = 0; k < 4; k++) begin : g_rot
    assign rot_in[k].x = hvd_pkg::GAIN_INV_Q30;
    assign rot_in[k].y = '0;
    assign rot_in[k].z = $signed({2'b00, ang[k]});
    hvd_cordic_row u_row (
      .clk    (clk),
      .en     (en),
      .vector (1'b0),
      .d_in   (rot_in[k]),
      .d_out  (rot_out[k])
    );
  end

  // Stages 4 to 11: clamp, products, sum, complement
  logic [30:0] s1_4, s2_4, c1_4, c2_4;
  logic [61:0] ccp_5;
  logic [30:0] s1_5, s2_5;
  logic [30:0] cc_6, s1_6, s2_6;
  logic [61:0] tp_7, s1sq_7;
  logic [30:0] s2_7;
  logic [30:0] t_8, s2_8;
  logic [61:0] s1sq_8;
  logic [61:0] tsp_9, s1sq_9;
  logic [62:0] sum_10;
  logic [60:0] a_10, a_11, na_11;

  always_comb begin
    sum_10 = 63'(s1sq_9) + 63'(tsp_9);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_4 <= clamp_q30($signed(rot_out[0].y));
      s2_4 <= clamp_q30($signed(rot_out[1].y));
      c1_4 <= clamp_q30($signed(rot_out[2].x));
      c2_4 <= clamp_q30($signed(rot_out[3].x));
      ccp_5 <= 62'(c1_4) * 62'(c2_4);
      s1_5 <= s1_4;
      s2_5 <= s2_4;
      cc_6 <= 31'((ccp_5 + 62'(1 << 29)) >> 30);
      s1_6 <= s1_5;
      s2_6 <= s2_5;
      tp_7   <= 62'(cc_6) * 62'(s2_6);
      s1sq_7 <= 62'(s1_6) * 62'(s1_6);
      s2_7   <= s2_6;
      t_8    <= 31'((tp_7 + 62'(1 << 29)) >> 30);
      s1sq_8 <= s1sq_7;
      s2_8   <= s2_7;
      tsp_9  <= 62'(t_8) * 62'(s2_8);
      s1sq_9 <= s1sq_8;
      a_10   <= (sum_10 > 63'(hvd_pkg::ONE_Q60)) ? hvd_pkg::ONE_Q60 : 61'(sum_10);
      a_11   <= a_10;
      na_11  <= hvd_pkg::ONE_Q60 - a_10;
    end
  end

  // Root chains: y from a, x from its complement
  hvd_pkg::root_t ry [hvd_pkg::ROOT_STEPS+1];
  hvd_pkg::root_t rx [hvd_pkg::ROOT_STEPS+1];

  assign ry[0].rem = hvd_pkg::RW'(a_11);
  assign ry[0].res = '0;
  assign rx[0].rem = hvd_pkg::RW'(na_11);
  assign rx[0].res = '0;

  for (genvar i = 0; i < hvd_pkg::ROOT_STEPS; i++) begin : g_root
    hvd_root_cell u_y (
      .clk   (clk),
      .en    (en),
      .step  (hvd_pkg::STEP_W'(i)),
      .d_in  (ry[i]),
      .d_out (ry[i+1])
    );
    hvd_root_cell u_x (
      .clk   (clk),
      .en    (en),
      .step  (hvd_pkg::STEP_W'(i)),
      .d_in  (rx[i]),
      .d_out (rx[i+1])
    );
  end

  // Vectoring row: half the central angle
  hvd_pkg::cdc_vec_t vec_in, vec_out;

  assign vec_in.x = $signed({3'b000, rx[hvd_pkg::ROOT_STEPS].res[30:0]});
  assign vec_in.y = $signed({3'b000, ry[hvd_pkg::ROOT_STEPS].res[30:0]});
  assign vec_in.z = '0;

  hvd_cordic_row u_vec (
    .clk    (clk),
    .en     (en),
    .vector (1'b1),
    .d_in   (vec_in),
    .d_out  (vec_out)
  );

  // Scale by the radius, then round, clamp and drop invalid pairs
  hvd_pkg::cdc_t zv;
  logic [31:0] zc;
  logic [54:0] dp;
  logic [29:0] dist_rnd;

  always_comb begin
    zv   = $signed(vec_out.z);
    zc   = (zv < 0) ? '0 : 32'(zv);
    dist_rnd = 30'((dp + (55'(1) << 24)) >> 25);
    if (dist_rnd > hvd_pkg::DIST_MAX) dist_rnd = hvd_pkg::DIST_MAX;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dp <= 55'(hvd_pkg::EARTH_RADIUS) * 55'(zc);
      coords_valid <= okp[LAT-2];
      distance_sixteenths <= okp[LAT-2] ? 29'(dist_rnd) : '0;
    end
  end

endmodule
